[src/kolt_pkg.sv]
// Shared constants and types of the keyed ordered list table.
`timescale 1ns / 1ps

package kolt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 64;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  found_key;
        logic [VAL_W-1:0]  found_value;
        logic [CNT_W-1:0]  entry_count;
    } res_t;

endpackage

[src/kolt_core.sv]
// Operation sequencer and entry memories of the keyed ordered list table.
`timescale 1ns / 1ps

module kolt_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         op_valid,
    output logic                         op_ready,
    input  logic [kolt_pkg::MODE_W-1:0]  op_mode,
    input  logic [kolt_pkg::KEY_W-1:0]   op_key,
    input  logic [kolt_pkg::VAL_W-1:0]   op_value,
    output logic                         res_valid,
    input  logic                         res_ready,
    output kolt_pkg::res_t               res
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_WAIT, S_DECIDE, S_READ, S_EXEC, S_PUSH_A, S_PUSH_B, S_RESULT
    } state_t;

    localparam int IW = kolt_pkg::IDX_W;
    localparam int CW = kolt_pkg::CNT_W;

    state_t                       state_reg;
    logic [kolt_pkg::MODE_W-1:0]  mode_reg;
    logic [kolt_pkg::KEY_W-1:0]   key_reg;
    logic [kolt_pkg::VAL_W-1:0]   value_reg;
    logic [IW-1:0]                scan_reg;
    logic [IW-1:0]                cmp_idx_reg;
    logic                         cmp_en_reg;
    logic                         hit_reg;
    logic [IW-1:0]                hit_idx_reg;
    logic                         free_reg;
    logic [IW-1:0]                free_idx_reg;
    logic [IW-1:0]                slot_reg;
    logic [IW-1:0]                first_reg;
    logic [IW-1:0]                last_reg;
    logic [CW-1:0]                count_reg;
    logic [kolt_pkg::CAPACITY-1:0] valid_reg;
    kolt_pkg::res_t               res_reg;

    logic [kolt_pkg::KEY_W-1:0] key_mem  [kolt_pkg::CAPACITY];
    logic [kolt_pkg::VAL_W-1:0] val_mem  [kolt_pkg::CAPACITY];
    logic [IW-1:0]              next_mem [kolt_pkg::CAPACITY];
    logic [IW-1:0]              prev_mem [kolt_pkg::CAPACITY];

    logic [kolt_pkg::KEY_W-1:0] rd_key;
    logic [kolt_pkg::VAL_W-1:0] rd_val;
    logic [IW-1:0]              rd_next;
    logic [IW-1:0]              rd_prev;
    logic [IW-1:0]              rd_addr;

    logic          kv_we;
    logic          nx_we;
    logic [IW-1:0] nx_addr;
    logic [IW-1:0] nx_data;
    logic          pv_we;
    logic [IW-1:0] pv_addr;
    logic [IW-1:0] pv_data;
    logic          is_front;
    logic          is_pop;
    logic [CW-1:0] count_dec;

    assign op_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;
    assign rd_addr   = (state_reg == S_SCAN) ? scan_reg : slot_reg;
    assign is_front  = (mode_reg == kolt_pkg::MODE_PUSH_FRONT);
    assign is_pop    = (mode_reg == kolt_pkg::MODE_POP_FRONT) ||
                       (mode_reg == kolt_pkg::MODE_POP_BACK);
    assign count_dec = count_reg - CW'(1);

    // link and payload writes of each step
    always_comb
    begin
        kv_we   = 1'b0;
        nx_we   = 1'b0;
        nx_addr = slot_reg;
        nx_data = slot_reg;
        pv_we   = 1'b0;
        pv_addr = slot_reg;
        pv_data = slot_reg;
        case (state_reg)
            S_PUSH_A:
            begin
                kv_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
                if (count_reg != '0)
                begin
                    if (is_front)
                        nx_data = first_reg;
                    else
                        pv_data = last_reg;
                end
            end
            S_PUSH_B:
            begin
                if (is_front)
                begin
                    pv_we   = 1'b1;
                    pv_addr = first_reg;
                end
                else
                begin
                    nx_we   = 1'b1;
                    nx_addr = last_reg;
                end
            end
            S_EXEC:
            begin
                if (mode_reg != kolt_pkg::MODE_FIND)
                begin
                    nx_we   = (slot_reg != first_reg);
                    nx_addr = rd_prev;
                    nx_data = rd_next;
                    pv_we   = (slot_reg != last_reg);
                    pv_addr = rd_next;
                    pv_data = rd_prev;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_key  <= key_mem[rd_addr];
        rd_val  <= val_mem[rd_addr];
        rd_next <= next_mem[rd_addr];
        rd_prev <= prev_mem[rd_addr];
        if (kv_we)
        begin
            key_mem[slot_reg] <= key_reg;
            val_mem[slot_reg] <= value_reg;
        end
        if (nx_we)
            next_mem[nx_addr] <= nx_data;
        if (pv_we)
            prev_mem[pv_addr] <= pv_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= '0;
            key_reg      <= '0;
            value_reg    <= '0;
            scan_reg     <= '0;
            cmp_idx_reg  <= '0;
            cmp_en_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            slot_reg     <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
            count_reg    <= '0;
            valid_reg    <= '0;
            res_reg      <= '0;
        end
        else
        begin
            cmp_en_reg  <= (state_reg == S_SCAN);
            cmp_idx_reg <= scan_reg;
            // compare the key word read in the previous cycle
            if (cmp_en_reg)
            begin
                if (valid_reg[cmp_idx_reg] && rd_key == key_reg && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                end
                if (!valid_reg[cmp_idx_reg] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cmp_idx_reg;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (op_valid)
                    begin
                        mode_reg  <= op_mode;
                        key_reg   <= op_key;
                        value_reg <= op_value;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        scan_reg  <= '0;
                        res_reg.status      <= kolt_pkg::STAT_MISSING;
                        res_reg.found_key   <= '0;
                        res_reg.found_value <= '0;
                        res_reg.entry_count <= count_reg;
                        case (op_mode) inside
                            kolt_pkg::MODE_PUSH_FRONT, kolt_pkg::MODE_PUSH_BACK,
                            kolt_pkg::MODE_FIND, kolt_pkg::MODE_ERASE:
                                state_reg <= S_SCAN;
                            kolt_pkg::MODE_POP_FRONT, kolt_pkg::MODE_POP_BACK:
                            begin
                                slot_reg  <= (op_mode == kolt_pkg::MODE_POP_FRONT) ?
                                             first_reg : last_reg;
                                state_reg <= (count_reg == '0) ? S_RESULT : S_READ;
                            end
                            default:
                                state_reg <= S_RESULT;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    scan_reg <= scan_reg + IW'(1);
                    if (scan_reg == IW'(kolt_pkg::CAPACITY - 1))
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                    state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    res_reg.found_key <= key_reg;
                    if (mode_reg == kolt_pkg::MODE_PUSH_FRONT ||
                        mode_reg == kolt_pkg::MODE_PUSH_BACK)
                    begin
                        if (hit_reg)
                        begin
                            res_reg.status <= kolt_pkg::STAT_PRESENT;
                            state_reg      <= S_RESULT;
                        end
                        else if (!free_reg || count_reg >= CW'(kolt_pkg::CAPACITY))
                        begin
                            res_reg.status <= kolt_pkg::STAT_FULL;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            slot_reg  <= free_idx_reg;
                            state_reg <= S_PUSH_A;
                        end
                    end
                    else if (hit_reg)
                    begin
                        slot_reg  <= hit_idx_reg;
                        state_reg <= S_READ;
                    end
                    else
                        state_reg <= S_RESULT;
                end
                S_READ:
                    state_reg <= S_EXEC;
                S_EXEC:
                begin
                    res_reg.status      <= kolt_pkg::STAT_OK;
                    res_reg.found_value <= rd_val;
                    res_reg.found_key   <= is_pop ? rd_key : key_reg;
                    if (mode_reg != kolt_pkg::MODE_FIND)
                    begin
                        valid_reg[slot_reg] <= 1'b0;
                        count_reg           <= count_dec;
                        res_reg.entry_count <= count_dec;
                        if (count_dec == '0)
                        begin
                            first_reg <= '0;
                            last_reg  <= '0;
                        end
                        else
                        begin
                            if (slot_reg == first_reg)
                                first_reg <= rd_next;
                            if (slot_reg == last_reg)
                                last_reg <= rd_prev;
                        end
                    end
                    state_reg <= S_RESULT;
                end
                S_PUSH_A:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    if (count_reg == '0)
                    begin
                        first_reg <= slot_reg;
                        last_reg  <= slot_reg;
                        state_reg <= S_PUSH_B;
                    end
                    else
                        state_reg <= S_PUSH_B;
                end
                S_PUSH_B:
                begin
                    if (count_reg != '0)
                    begin
                        if (is_front)
                            first_reg <= slot_reg;
                        else
                            last_reg <= slot_reg;
                    end
                    count_reg           <= count_reg + CW'(1);
                    res_reg.entry_count <= count_reg + CW'(1);
                    res_reg.status      <= kolt_pkg::STAT_OK;
                    res_reg.found_value <= value_reg;
                    state_reg           <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[src/keyed_ordered_list_table_top.sv]
// Top level of the keyed ordered list table: stream ports and result register.
`timescale 1ns / 1ps

// Holds up to 64 keyed entries in a doubly linked order; each input word runs one
// push, pop, find or erase and returns one result word. Push, find and erase scan
// the key memory one entry per cycle, since the entry memories have a single read
// port; pops go straight to the first or last entry. One operation runs at a time;
// a finished result waits in the output register while the next input word is
// taken.
module keyed_ordered_list_table_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // mode[2:0], key[34:3], value[98:35]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata   // status[1:0], found_key[33:2],
                                        // found_value[97:34], entry_count[104:98]
);

    logic           res_valid;
    logic           res_ready;
    kolt_pkg::res_t res;
    kolt_pkg::res_t out_reg;
    logic           out_valid_reg;

    assign res_ready = !out_valid_reg || m_axis_tready;

    kolt_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (s_axis_tvalid),
        .op_ready (s_axis_tready),
        .op_mode  (s_axis_tdata[2:0]),
        .op_key   (s_axis_tdata[34:3]),
        .op_value (s_axis_tdata[98:35]),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
                out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.entry_count, out_reg.found_value,
                            out_reg.found_key, out_reg.status};

endmodule

[test/tb.sv]
// Self-checking testbench of the keyed ordered list table.
`timescale 1ns / 1ps

module tb;

    localparam logic [kolt_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [kolt_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

    typedef struct {
        logic [kolt_pkg::STAT_W-1:0] status;
        logic [kolt_pkg::KEY_W-1:0]  found_key;
        logic [kolt_pkg::VAL_W-1:0]  found_value;
        logic [6:0]                  entry_count;
    } table_result_t;

    class table_scoreboard;
        logic [kolt_pkg::KEY_W-1:0] keys[kolt_pkg::CAPACITY];
        logic [kolt_pkg::VAL_W-1:0] vals[kolt_pkg::CAPACITY];
        int               nxt[kolt_pkg::CAPACITY];
        int               prv[kolt_pkg::CAPACITY];
        bit               used[kolt_pkg::CAPACITY];
        int               head;
        int               tail;
        int               count;
        table_result_t    pending[$];
        int               errors;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            errors = 0;
            for (int i = 0; i < kolt_pkg::CAPACITY; i++)
                used[i] = 0;
        endfunction

        function int slot_of(logic [kolt_pkg::KEY_W-1:0] k);
            for (int i = 0; i < kolt_pkg::CAPACITY; i++)
                if (used[i] && keys[i] == k)
                    return i;
            return -1;
        endfunction

        function void unlink(int s);
            int p;
            int n;
            p = prv[s];
            n = nxt[s];
            if (s == head)
                head = n;
            else
                nxt[p] = n;
            if (s == tail)
                tail = p;
            else
                prv[n] = p;
            used[s] = 0;
            count--;
            if (count == 0)
            begin
                head = 0;
                tail = 0;
            end
        endfunction

        function void note_input(logic [kolt_pkg::MODE_W-1:0] mode,
                                 logic [kolt_pkg::KEY_W-1:0] k,
                                 logic [kolt_pkg::VAL_W-1:0] v);
            table_result_t r;
            int            s;
            r.status = kolt_pkg::STAT_MISSING;
            r.found_key = '0;
            r.found_value = '0;
            if (mode == kolt_pkg::MODE_PUSH_FRONT || mode == kolt_pkg::MODE_PUSH_BACK)
            begin
                r.found_key = k;
                s = -1;
                for (int i = kolt_pkg::CAPACITY - 1; i >= 0; i--)
                    if (!used[i])
                        s = i;
                if (slot_of(k) >= 0)
                    r.status = kolt_pkg::STAT_PRESENT;
                else if (s < 0)
                    r.status = kolt_pkg::STAT_FULL;
                else
                begin
                    keys[s] = k;
                    vals[s] = v;
                    used[s] = 1;
                    if (count == 0)
                    begin
                        head = s;
                        tail = s;
                        nxt[s] = s;
                        prv[s] = s;
                    end
                    else if (mode == kolt_pkg::MODE_PUSH_FRONT)
                    begin
                        nxt[s] = head;
                        prv[s] = s;
                        prv[head] = s;
                        head = s;
                    end
                    else
                    begin
                        prv[s] = tail;
                        nxt[s] = s;
                        nxt[tail] = s;
                        tail = s;
                    end
                    count++;
                    r.status = kolt_pkg::STAT_OK;
                    r.found_value = v;
                end
            end
            else if (mode == kolt_pkg::MODE_POP_FRONT || mode == kolt_pkg::MODE_POP_BACK)
            begin
                if (count != 0)
                begin
                    s = (mode == kolt_pkg::MODE_POP_FRONT) ? head : tail;
                    r.found_key = keys[s];
                    r.found_value = vals[s];
                    unlink(s);
                    r.status = kolt_pkg::STAT_OK;
                end
            end
            else if (mode == kolt_pkg::MODE_FIND || mode == kolt_pkg::MODE_ERASE)
            begin
                r.found_key = k;
                s = slot_of(k);
                if (s >= 0)
                begin
                    r.found_value = vals[s];
                    if (mode == kolt_pkg::MODE_ERASE)
                        unlink(s);
                    r.status = kolt_pkg::STAT_OK;
                end
            end
            r.entry_count = count[6:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [111:0] d);
            table_result_t e;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected: %h", d);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (d[1:0] !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, d[1:0]);
                errors++;
            end
            if (d[33:2] !== e.found_key)
            begin
                $error("found_key expected %h actual %h", e.found_key, d[33:2]);
                errors++;
            end
            if (d[97:34] !== e.found_value)
            begin
                $error("found_value expected %h actual %h", e.found_value, d[97:34]);
                errors++;
            end
            if (d[104:98] !== e.entry_count)
            begin
                $error("entry_count expected %0d actual %0d", e.entry_count, d[104:98]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;

    table_scoreboard  board;
    bit               quiet;
    bit               sending_done;
    int               cycles;
    logic [kolt_pkg::KEY_W-1:0] key_pool[16];

    keyed_ordered_list_table_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        quiet = 0;
        sending_done = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 900000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end
    initial cycles = 0;

    // Receiver: random stall bursts, sampled at the edge where a word moves.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    task automatic send_word(logic [kolt_pkg::MODE_W-1:0] mode,
                             logic [kolt_pkg::KEY_W-1:0] k,
                             logic [kolt_pkg::VAL_W-1:0] v);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, v, k, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_input(mode, k, v);
    endtask

    function automatic logic [kolt_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, 15)];
        return $urandom();
    endfunction

    initial
    begin
        logic [kolt_pkg::MODE_W-1:0] mode;
        int                w;
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extremes, duplicates, every mode incl. unused codes
        send_word(kolt_pkg::MODE_POP_FRONT, '1, '1);
        send_word(kolt_pkg::MODE_POP_BACK, '0, '0);
        send_word(kolt_pkg::MODE_FIND, '0, '0);
        send_word(kolt_pkg::MODE_ERASE, '1, '0);
        send_word(kolt_pkg::MODE_PUSH_FRONT, '0, '1);
        send_word(kolt_pkg::MODE_PUSH_BACK, '1, '0);
        send_word(kolt_pkg::MODE_PUSH_FRONT, 32'h5, 64'h5555_5555_5555_5555);
        send_word(kolt_pkg::MODE_PUSH_BACK, '1, 64'h1);
        send_word(kolt_pkg::MODE_FIND, '1, '0);
        send_word(MODE_SPARE_A, 32'h5, '1);
        send_word(MODE_SPARE_B, '1, '1);
        send_word(kolt_pkg::MODE_ERASE, '0, '0);
        send_word(kolt_pkg::MODE_FIND, '0, '0);
        send_word(kolt_pkg::MODE_POP_BACK, '0, '0);
        send_word(kolt_pkg::MODE_POP_FRONT, '0, '0);
        send_word(kolt_pkg::MODE_POP_FRONT, '0, '0);
        // fill to capacity, then refusals, an erase and refill, and pops until empty
        for (int i = 0; i < kolt_pkg::CAPACITY; i++)
            send_word(i[0] ? kolt_pkg::MODE_PUSH_BACK : kolt_pkg::MODE_PUSH_FRONT,
                      32'h100 + i, {$urandom, $urandom});
        send_word(kolt_pkg::MODE_PUSH_BACK, 32'h9999, '1);
        send_word(kolt_pkg::MODE_PUSH_FRONT, 32'h100, '1);
        send_word(kolt_pkg::MODE_ERASE, 32'h120, '0);
        send_word(kolt_pkg::MODE_PUSH_BACK, 32'h777, '1);
        for (int i = 0; i < kolt_pkg::CAPACITY; i++)
            send_word($urandom_range(0, 1) ? kolt_pkg::MODE_POP_FRONT :
                      kolt_pkg::MODE_POP_BACK, '0, '0);

        for (int i = 0; i < 1700; i++)
        begin
            if (i > 1500)
                quiet = 1;
            w = $urandom_range(0, 99);
            if (w < 35)
                mode = $urandom_range(0, 1) ? kolt_pkg::MODE_PUSH_BACK :
                       kolt_pkg::MODE_PUSH_FRONT;
            else if (w < 55)
                mode = $urandom_range(0, 1) ? kolt_pkg::MODE_POP_BACK :
                       kolt_pkg::MODE_POP_FRONT;
            else if (w < 75)
                mode = kolt_pkg::MODE_FIND;
            else if (w < 97)
                mode = kolt_pkg::MODE_ERASE;
            else
                mode = $urandom_range(0, 1) ? MODE_SPARE_B : MODE_SPARE_A;
            send_word(mode, pick_key(), {$urandom, $urandom});
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[filelist.f]
src/kolt_pkg.sv
src/kolt_core.sv
src/keyed_ordered_list_table_top.sv
test/tb.sv
